// ----- rtl/sghb_pkg.sv -----
// ----------------------------------------------------------------------------
// sghb_pkg
// shared types and constants of the sparse-grid hat basis evaluation unit
// ----------------------------------------------------------------------------
package sghb_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_DIMS_DEF   = 5;

    localparam int VAL_W   = 25;
    localparam int IDX_W   = 16;
    localparam int LVL_W   = 17;
    localparam int COEF_W  = 32;
    localparam int SUM_W   = 48;
    localparam int KIND_W  = 2;
    localparam int Q24_W   = 25;
    localparam int ACC_W   = 64;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd2;

    // register indexes
    localparam int REG_DIM_COUNT = 0;

endpackage

// ----- rtl/sghb_ram.sv -----
// ----------------------------------------------------------------------------
// sghb_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module sghb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/sghb_front.sv -----
// ----------------------------------------------------------------------------
// sghb_front
// accepts item beats and pushes them into a two-entry queue for the back end
// ----------------------------------------------------------------------------
module sghb_front #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         q_valid,
    input  logic         q_pop,
    output logic [W-1:0] q_data
);
    logic [W-1:0] slot_reg [2];
    logic [1:0]   cnt_reg, cnt_next;
    logic         rd_reg, wr_reg;
    logic         push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (q_pop && q_valid) rd_reg <= ~rd_reg;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_reg] <= in_data;
    end
endmodule

// ----- rtl/sghb_back.sv -----
// ----------------------------------------------------------------------------
// sghb_back
// executes queued items: table clear, point append, and evaluation that
// walks one dimension of one stored point per cycle
// ----------------------------------------------------------------------------
module sghb_back #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 5,
    parameter int W          = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           dims,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic [W-1:0]         q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [sghb_pkg::SUM_W-1:0] m_sum,
    output logic                 m_sat
);
    import sghb_pkg::*;

    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SD = MAX_POINTS * MAX_DIMS;
    localparam int SW = $clog2(SD);

    typedef enum logic [2:0] {
        S_IDLE, S_APPEND, S_EVAL, S_DRAIN, S_OUT
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           count_reg;
    logic [DW-1:0]           d_reg;
    logic [PW-1:0]           p_reg;
    logic [CW-1:0]           rp_reg;
    logic [DW-1:0]           rd_reg;
    logic [W-1:0]            item_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic                    sat_reg, mval_reg;

    // pipeline of read stage
    logic                    v1_reg, last1_reg, first1_reg;
    logic [DW-1:0]           d1_reg;
    logic                    v2_reg, last2_reg, first2_reg;
    logic [Q24_W-1:0]        hat2_reg;
    logic [Q24_W-1:0]        prod_reg;
    logic                    pv_reg;
    logic                    tv_reg;
    logic signed [COEF_W+Q24_W:0] term_full_reg;
    logic                    tv2_reg;
    logic signed [COEF_W+1:0] term_reg;
    logic [COEF_W-1:0]       coef_hold_reg;
    logic [COEF_W-1:0]       coef2_reg;

    // memories
    logic                    we_s, we_c;
    logic [SW-1:0]           waddr_s, raddr_s;
    logic [LVL_W-1:0]        lvl_rd;
    logic [IDX_W-1:0]        idx_rd;
    logic [COEF_W-1:0]       coef_rd;

    logic [2:0]              act;
    logic [DW-1:0]           last_d;
    logic [VAL_W-1:0]        x_sel;
    logic [IDX_W-1:0]        idx_sel;
    logic [KIND_W-1:0]       kind;

    assign kind = q_data[KIND_W-1:0];
    assign act  = (dims == 3'd0) ? 3'd1 :
                  (dims > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : dims;
    assign last_d = DW'(act - 3'd1);

    // field selection of the held item
    always_comb begin
        x_sel   = item_reg[KIND_W + d1_reg*VAL_W +: VAL_W];
        idx_sel = item_reg[KIND_W + 5*VAL_W + d_reg*IDX_W +: IDX_W];
    end

    assign we_s    = (state_reg == S_APPEND);
    assign we_c    = (state_reg == S_APPEND) && (d_reg == '0);
    assign waddr_s = SW'(p_reg * MAX_DIMS + d_reg);
    assign raddr_s = SW'(rp_reg[PW-1:0] * MAX_DIMS + rd_reg);

    sghb_ram #(.WIDTH(LVL_W), .DEPTH(SD)) u_lvl (
        .aclk(aclk), .we(we_s), .waddr(waddr_s),
        .wdata(item_reg[KIND_W + d_reg*VAL_W +: LVL_W]),
        .raddr(raddr_s), .rdata(lvl_rd));
    sghb_ram #(.WIDTH(IDX_W), .DEPTH(SD)) u_idx (
        .aclk(aclk), .we(we_s), .waddr(waddr_s), .wdata(idx_sel),
        .raddr(raddr_s), .rdata(idx_rd));
    sghb_ram #(.WIDTH(COEF_W), .DEPTH(MAX_POINTS)) u_coef (
        .aclk(aclk), .we(we_c), .waddr(p_reg),
        .wdata(item_reg[KIND_W + 5*VAL_W + 5*IDX_W +: COEF_W]),
        .raddr(rp_reg[PW-1:0]), .rdata(coef_rd));

    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign m_valid = mval_reg;
    assign m_sum   = sum_reg;
    assign m_sat   = sat_reg;

    logic issue;
    logic [41:0] e_w;
    logic signed [43:0] t_w;
    logic [43:0] a_w;
    logic [Q24_W-1:0] hat_w;
    logic [2*Q24_W-1:0] mul_w;
    logic [Q24_W-1:0] base_w;
    logic signed [ACC_W-1:0] acc_s;

    assign issue = (state_reg == S_EVAL);

    // hat of one dimension and the running product, two multiplies
    always_comb begin
        e_w   = 42'(lvl_rd) * 42'(x_sel);
        t_w   = $signed({2'b00, e_w}) - $signed({4'b0, idx_rd, 24'b0});
        a_w   = t_w[43] ? 44'(-t_w) : 44'(t_w);
        hat_w = (a_w >= 44'(1 << 24)) ? '0 : Q24_W'((1 << 24) - a_w);
        base_w = first2_reg ? Q24_W'(1 << 24) : prod_reg;
        mul_w = 50'(base_w) * 50'(hat2_reg);
        acc_s = $signed(acc_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mval_reg  <= 1'b0;
            v1_reg <= 1'b0; v2_reg <= 1'b0; pv_reg <= 1'b0;
            tv_reg <= 1'b0; tv2_reg <= 1'b0;
        end else begin
            // read stage then hat stage then product stage
            v1_reg     <= issue;
            last1_reg  <= (rd_reg == last_d);
            first1_reg <= (rd_reg == '0);
            d1_reg     <= rd_reg;
            v2_reg     <= v1_reg;
            last2_reg  <= last1_reg;
            first2_reg <= first1_reg;
            hat2_reg   <= hat_w;
            if (v1_reg && first1_reg) coef_hold_reg <= coef_rd;
            // coefficient follows its point into the term stage
            if (v2_reg && last2_reg) coef2_reg <= coef_hold_reg;
            pv_reg <= v2_reg && last2_reg;
            if (v2_reg) prod_reg <= Q24_W'(mul_w >> 24);
            // term = coef * prod, then floor shift
            tv_reg <= pv_reg;
            term_full_reg <= $signed(coef2_reg) * $signed({1'b0, prod_reg});
            tv2_reg <= tv_reg;
            term_reg <= (COEF_W+2)'(term_full_reg >>> 24);
            if (tv2_reg) acc_reg <= ACC_W'(acc_s + ACC_W'(term_reg));

            if (m_valid && m_ready) mval_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg <= q_data;
                        d_reg    <= '0;
                        p_reg    <= count_reg[PW-1:0];
                        rp_reg   <= '0;
                        rd_reg   <= '0;
                        acc_reg  <= '0;
                        unique case (kind)
                            KIND_CLEAR:  count_reg <= '0;
                            KIND_APPEND: if (count_reg < CW'(MAX_POINTS))
                                state_reg <= S_APPEND;
                            KIND_EVAL:   state_reg <= (count_reg == '0) ?
                                S_DRAIN : S_EVAL;
                            default: ;
                        endcase
                    end
                end
                S_APPEND: begin
                    if (d_reg == DW'(MAX_DIMS - 1)) begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
                S_EVAL: begin
                    if (rd_reg == last_d) begin
                        rd_reg <= '0;
                        if (rp_reg + 1'b1 == count_reg) state_reg <= S_DRAIN;
                        rp_reg <= rp_reg + 1'b1;
                    end else begin
                        rd_reg <= rd_reg + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!v1_reg && !v2_reg && !pv_reg && !tv_reg && !tv2_reg
                        && !mval_reg) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (acc_s > ACC_W'(64'sh7FFFFFFFFFFF)) begin
                        sum_reg <= 48'h7FFFFFFFFFFF; sat_reg <= 1'b1;
                    end else if (acc_s < -ACC_W'(64'sh800000000000)) begin
                        sum_reg <= 48'h800000000000; sat_reg <= 1'b1;
                    end else begin
                        sum_reg <= acc_reg[SUM_W-1:0]; sat_reg <= 1'b0;
                    end
                    mval_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/sparse_grid_hat_basis_evaluate_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_grid_hat_basis_evaluate_unit
// sparse-grid hat basis table with append, clear and evaluate beats
// ----------------------------------------------------------------------------
// Clear beats finish in the idle state and append beats write every dimension
// in S_APPEND. An evaluation walks the table one dimension of one stored
// point per cycle through the level and index rams; the single read port of
// those rams sets this rate. A two-entry queue lets input beats arrive while
// the back end works.
module sparse_grid_hat_basis_evaluate_unit #(
    parameter int MAX_POINTS = sghb_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = sghb_pkg::MAX_DIMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind, value_0..value_4, index_0..index_4, coefficient, zero pad
    input  logic [239:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sum
    output logic [47:0] m_tdata,
    // saturated
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sghb_pkg::*;

    localparam int IW = KIND_W + 5*VAL_W + 5*IDX_W + COEF_W;

    logic [2:0]    dim_reg;
    logic          q_valid, q_pop;
    logic [IW-1:0] q_data;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'(REG_DIM_COUNT*4)) ? {29'b0, dim_reg} : '0;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= 3'd5;
        end else if (psel && penable && pwrite && paddr == 2'(REG_DIM_COUNT*4)) begin
            dim_reg <= pwdata[2:0];
        end
    end

    sghb_front #(.W(IW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid),
        .in_ready(s_tready), .in_data(s_tdata[IW-1:0]),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

    sghb_back #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS), .W(IW)) u_back (
        .aclk(aclk), .aresetn(aresetn), .dims(dim_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_sum(m_tdata), .m_sat(m_tuser));

`ifndef NO_ASSERTIONS
    // result stays up while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    // queue never pops when empty
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif
endmodule
